FILE: src/midpoint_ellipse_rasterizer_defines.svh
// Assertion macros shared by the ellipse rasterizer checker.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MER_ASSERT_NOW(name, clk_i, rst_ni, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MER_ASSERT_NXT(name, clk_i, rst_ni, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mer_pkg.sv
// Shared constants for the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int COLOR_WIDTH_DEF = 24;

    // Input word kinds, carried on s_tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

FILE: src/mer_mul.sv
// Shared signed multiplier with registered product.
module mer_mul #(
    parameter int W = 28
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] product
);

    always_ff @(posedge clk)
    begin
        product <= a * b;
    end

endmodule

FILE: src/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level: sequencer, state and output word register.
// Start word: setup in S_RY2, S_RX2, S_RXRY and S_INIT, then S_CHECK, then 2 or 4 output words.
// Step word: S_STEP_A and S_STEP_B, then S_CHECK, then 2 or 4 output words.
// Either word passes S_SW1 to S_SW5 when region two begins; output words go at one per cycle while m_tready is high.
// A step after completion is accepted in S_IDLE and produces nothing.
// rst_n is asynchronous, active low; all state clears to idle with no ellipse active.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COLOR_WIDTH = COLOR_WIDTH_DEF,
    localparam int RW     = COORD_WIDTH - 1,
    localparam int OW     = COORD_WIDTH + 1,
    localparam int IN_BITS  = 1 + 2 * COORD_WIDTH + 2 * RW + COLOR_WIDTH,
    localparam int IN_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 3 * OW + COLOR_WIDTH,
    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // fill_mode, center_x, center_y, radius_x, radius_y, color (low bit up)
    input  logic [IN_W-1:0]  s_tdata,
    // operation
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // row, col_first, col_last, pixel_color (low bit up)
    output logic [OUT_W-1:0] m_tdata,
    // done_res
    output logic             m_tuser,
    output logic             m_tlast
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = 2 * RW;            // squared radius
    localparam int AW = 3 * CW;            // accum_px / accum_py
    localparam int DW = 4 * CW;            // decision
    localparam int MW = 2 * CW + 4;        // multiplier operand
    localparam int PW = 2 * MW;            // multiplier product

    // input field offsets
    localparam int CX_LO  = 1;
    localparam int CY_LO  = CX_LO + CW;
    localparam int RX_LO  = CY_LO + CW;
    localparam int RY_LO  = RX_LO + RW;
    localparam int COL_LO = RY_LO + RW;

    localparam logic signed [MW-1:0] MW_ONE = MW'(1);
    localparam logic signed [OW-1:0] OW_ONE = OW'(1);
    localparam logic signed [OW-1:0] OW_TWO = OW'(2);
    localparam logic [1:0] K_FILL_LAST = 2'd1;
    localparam logic [1:0] K_OUT_LAST  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RY2,      // issue ry*ry
        S_RX2,      // take ry2, issue rx*rx
        S_RXRY,     // take rx2, issue rx2*ry
        S_INIT,     // initial accumulators and decision
        S_CHECK,    // region switch test and completion
        S_SW1,      // issue ry2 * px(px+1)
        S_SW2,      // add, issue (py-1)^2
        S_SW3,      // issue rx2 * (py-1)^2
        S_SW4,      // add, issue rx2*ry2
        S_SW5,      // subtract
        S_STEP_A,   // move position and accumulators
        S_STEP_B,   // update decision
        S_EMIT      // one output word per cycle while m_tready allows
    } state_t;

    state_t state_reg, state_next;

    logic signed [CW-1:0]  ctr_x_reg, ctr_x_next, ctr_y_reg, ctr_y_next;
    logic [RW-1:0]         rad_x_reg, rad_x_next, rad_y_reg, rad_y_next;
    logic [COLOR_WIDTH-1:0] draw_color_reg, draw_color_next;
    logic                  filling_reg, filling_next;
    logic [SW-1:0]         rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic signed [OW-1:0]  pos_x_reg, pos_x_next;
    logic signed [CW-1:0]  pos_y_reg, pos_y_next;
    logic signed [AW-1:0]  accum_px_reg, accum_px_next, accum_py_reg, accum_py_next;
    logic signed [DW-1:0]  decision_reg, decision_next;
    logic                  region_two_reg, region_two_next;
    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic                  move_x_reg, move_x_next, move_y_reg, move_y_next;
    logic [1:0]            k_reg, k_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [OW-1:0]  row_reg, row_next;
    logic signed [OW-1:0]  col_first_reg, col_first_next, col_last_reg, col_last_next;
    logic [COLOR_WIDTH-1:0] out_color_reg, out_color_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    // multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [MW-1:0] ry_m, rx_m, rx2_m, ry2_m, px_m, px1_m, py1_m, prod_m, sq_m;
    logic signed [DW-1:0] prod_d, apx_d, apy_d;
    logic [AW-1:0]        two_ry2, two_rx2;

    // branch terms of one loop iteration
    logic dec_neg, dec_pos, branch, move_x, move_y;
    logic switch_now, done_now;

    // output geometry
    logic signed [OW-1:0] cx_e, cy_e, py_e;
    logic signed [OW-1:0] top_row, bot_row, left_col, right_col, span_end;
    logic                 k_last;

    mer_mul #(
        .W (MW)
    ) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    assign ry_m   = MW'($signed({1'b0, rad_y_reg}));
    assign rx_m   = MW'($signed({1'b0, rad_x_reg}));
    assign rx2_m  = MW'($signed({1'b0, rx2_reg}));
    assign ry2_m  = MW'($signed({1'b0, ry2_reg}));
    assign sq_m   = MW'($signed({1'b0, mul_p[SW-1:0]}));
    assign px_m   = MW'(pos_x_reg);
    assign px1_m  = px_m + MW_ONE;
    assign py1_m  = MW'(pos_y_reg) - MW_ONE;
    assign prod_m = $signed(mul_p[MW-1:0]);
    assign prod_d = $signed(mul_p[DW-1:0]);
    assign apx_d  = DW'(accum_px_reg);
    assign apy_d  = DW'(accum_py_reg);
    assign two_ry2 = AW'({ry2_reg, 1'b0});
    assign two_rx2 = AW'({rx2_reg, 1'b0});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_RY2:
            begin
                mul_a = ry_m;
                mul_b = ry_m;
            end
            S_RX2:
            begin
                mul_a = rx_m;
                mul_b = rx_m;
            end
            S_RXRY:
            begin
                mul_a = sq_m;
                mul_b = ry_m;
            end
            S_CHECK:
            begin
                mul_a = px_m;
                mul_b = px1_m;
            end
            S_SW1:
            begin
                mul_a = ry2_m;
                mul_b = prod_m;
            end
            S_SW2:
            begin
                mul_a = py1_m;
                mul_b = py1_m;
            end
            S_SW3:
            begin
                mul_a = rx2_m;
                mul_b = prod_m;
            end
            S_SW4:
            begin
                mul_a = rx2_m;
                mul_b = ry2_m;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // region one tests decision < 0, region two tests decision > 0
    assign dec_neg = decision_reg[DW-1];
    assign dec_pos = !dec_neg && (decision_reg != '0);
    assign branch  = region_two_reg ? dec_pos : dec_neg;
    assign move_x  = !region_two_reg || !branch;
    assign move_y  = region_two_reg || !branch;

    assign switch_now = !region_two_reg && !(accum_px_reg < accum_py_reg);
    assign done_now   = (switch_now || region_two_reg) && !pos_y_reg[CW-1];

    // pixel set: rows cy+y and cy-y-1, columns cx+x and cx-x-1
    assign cx_e      = OW'(ctr_x_reg);
    assign cy_e      = OW'(ctr_y_reg);
    assign py_e      = OW'(pos_y_reg);
    assign top_row   = cy_e + py_e;
    assign bot_row   = cy_e - py_e - OW_ONE;
    assign left_col  = cx_e + pos_x_reg;
    assign right_col = cx_e - pos_x_reg - OW_ONE;
    assign span_end  = cx_e - pos_x_reg - OW_TWO;
    assign k_last    = (k_reg == (filling_reg ? K_FILL_LAST : K_OUT_LAST));

    always_comb
    begin
        state_next      = state_reg;
        ctr_x_next      = ctr_x_reg;
        ctr_y_next      = ctr_y_reg;
        rad_x_next      = rad_x_reg;
        rad_y_next      = rad_y_reg;
        draw_color_next = draw_color_reg;
        filling_next    = filling_reg;
        rx2_next        = rx2_reg;
        ry2_next        = ry2_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        accum_px_next   = accum_px_reg;
        accum_py_next   = accum_py_reg;
        decision_next   = decision_reg;
        region_two_next = region_two_reg;
        active_next     = active_reg;
        done_next       = done_reg;
        move_x_next     = move_x_reg;
        move_y_next     = move_y_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        row_next        = row_reg;
        col_first_next  = col_first_reg;
        col_last_next   = col_last_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_START)
                    begin
                        filling_next    = s_tdata[0];
                        ctr_x_next      = $signed(s_tdata[CX_LO +: CW]);
                        ctr_y_next      = $signed(s_tdata[CY_LO +: CW]);
                        rad_x_next      = s_tdata[RX_LO +: RW];
                        rad_y_next      = s_tdata[RY_LO +: RW];
                        draw_color_next = s_tdata[COL_LO +: COLOR_WIDTH];
                        pos_x_next      = -OW_ONE;
                        pos_y_next      = -$signed({1'b0, s_tdata[RY_LO +: RW]});
                        region_two_next = 1'b0;
                        active_next     = 1'b1;
                        state_next      = S_RY2;
                    end
                    else if (active_reg)
                    begin
                        state_next = S_STEP_A;
                    end
                end
            end
            S_RY2:
            begin
                state_next = S_RX2;
            end
            S_RX2:
            begin
                ry2_next   = mul_p[SW-1:0];
                state_next = S_RXRY;
            end
            S_RXRY:
            begin
                rx2_next   = mul_p[SW-1:0];
                state_next = S_INIT;
            end
            S_INIT:
            begin
                // product is rx2*ry
                accum_px_next = $signed(two_ry2);
                accum_py_next = $signed({mul_p[AW-2:0], 1'b0});
                decision_next = $signed(DW'({ry2_reg, 2'b00})) - prod_d
                              + $signed(DW'(rx2_reg >> 2));
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                done_next   = done_now;
                active_next = !done_now;
                k_next      = '0;
                if (switch_now)
                begin
                    region_two_next = 1'b1;
                    decision_next   = $signed(DW'(rx2_reg)) - apy_d;
                    state_next      = S_SW1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SW1:
            begin
                state_next = S_SW2;
            end
            S_SW2:
            begin
                decision_next = decision_reg + prod_d;
                state_next    = S_SW3;
            end
            S_SW3:
            begin
                state_next = S_SW4;
            end
            S_SW4:
            begin
                decision_next = decision_reg + prod_d;
                state_next    = S_SW5;
            end
            S_SW5:
            begin
                decision_next = decision_reg - prod_d;
                state_next    = S_EMIT;
            end
            S_STEP_A:
            begin
                move_x_next = move_x;
                move_y_next = move_y;
                if (move_x)
                begin
                    pos_x_next    = pos_x_reg - OW_ONE;
                    accum_px_next = accum_px_reg + $signed(two_ry2);
                end
                if (move_y)
                begin
                    pos_y_next    = pos_y_reg + CW'(1);
                    accum_py_next = accum_py_reg - $signed(two_rx2);
                end
                state_next = S_STEP_B;
            end
            S_STEP_B:
            begin
                decision_next = decision_reg
                              + $signed(DW'(region_two_reg ? rx2_reg : ry2_reg))
                              + (move_x_reg ? apx_d : '0)
                              - (move_y_reg ? apy_d : '0);
                state_next    = S_CHECK;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = draw_color_reg;
                    out_last_next  = k_last;
                    out_done_next  = done_reg;
                    if (filling_reg)
                    begin
                        row_next       = k_reg[0] ? bot_row : top_row;
                        col_first_next = left_col;
                        col_last_next  = span_end;
                    end
                    else
                    begin
                        row_next       = k_reg[1] ? bot_row : top_row;
                        col_first_next = k_reg[0] ? right_col : left_col;
                        col_last_next  = k_reg[0] ? right_col : left_col;
                    end
                    k_next = k_reg + 2'd1;
                    if (k_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ctr_x_reg      <= '0;
            ctr_y_reg      <= '0;
            rad_x_reg      <= '0;
            rad_y_reg      <= '0;
            draw_color_reg <= '0;
            filling_reg    <= 1'b0;
            rx2_reg        <= '0;
            ry2_reg        <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            accum_px_reg   <= '0;
            accum_py_reg   <= '0;
            decision_reg   <= '0;
            region_two_reg <= 1'b0;
            active_reg     <= 1'b0;
            done_reg       <= 1'b0;
            move_x_reg     <= 1'b0;
            move_y_reg     <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            row_reg        <= '0;
            col_first_reg  <= '0;
            col_last_reg   <= '0;
            out_color_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ctr_x_reg      <= ctr_x_next;
            ctr_y_reg      <= ctr_y_next;
            rad_x_reg      <= rad_x_next;
            rad_y_reg      <= rad_y_next;
            draw_color_reg <= draw_color_next;
            filling_reg    <= filling_next;
            rx2_reg        <= rx2_next;
            ry2_reg        <= ry2_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            accum_px_reg   <= accum_px_next;
            accum_py_reg   <= accum_py_next;
            decision_reg   <= decision_next;
            region_two_reg <= region_two_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
            move_x_reg     <= move_x_next;
            move_y_reg     <= move_y_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
            row_reg        <= row_next;
            col_first_reg  <= col_first_next;
            col_last_reg   <= col_last_next;
            out_color_reg  <= out_color_next;
            out_last_reg   <= out_last_next;
            out_done_reg   <= out_done_next;
        end
    end

    // input is taken only between words; the final output word may still wait
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_color_reg, col_last_reg, col_first_reg, row_reg});
    assign m_tuser  = out_done_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/mer_checker.sv
// Port-level assertion checker for the ellipse rasterizer, with its bind.
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_checker
    import mer_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COLOR_WIDTH = COLOR_WIDTH_DEF,
    localparam int OUT_BITS = 3 * (COORD_WIDTH + 1) + COLOR_WIDTH,
    localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    // stalled word holds
    `MER_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // no new input while a set is still going out
    `MER_ASSERT_NOW(a_busy_set, clk, rst_n, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of a set")

    // a start keeps the block busy for setup
    `MER_ASSERT_NXT(a_start_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == OP_START), !s_tready, "ready right after a start")

    // words of one set follow back to back with the same done flag
    `MER_ASSERT_NXT(a_set_done, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser)), "done flag differs inside a set")

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .COLOR_WIDTH (COLOR_WIDTH)
) u_mer_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
